// File: rtl/rc4_pkg.sv
// Shared types, constants and codes for the RC4 stream cipher unit.
package rc4_pkg;

  // Fixed widths and the permutation depth of the data path.
  localparam int BYTE_W     = 8;
  localparam int KLEN_W     = 9;
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;

  // Default size of the key store.
  localparam int MAX_KEY_BYTES_DEF = 256;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_KSA   = 2'd1,
    OP_CRYPT = 2'd2,
    OP_RSVD  = 2'd3
  } rc4_op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_FILL,
    ST_K_RD_N,
    ST_K_RD_J,
    ST_K_WR_N,
    ST_K_WR_J,
    ST_D_RD_I,
    ST_D_RD_J,
    ST_D_SWAP,
    ST_D_WR_J
  } rc4_state_t;

  // Result handed from the core to the output register.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] out_byte;
    logic              not_keyed;
  } rc4_res_t;

endpackage

// File: rtl/rc4_stream_cipher_unit.sv
// Top level of the RC4 stream cipher unit: key length register, core and output register.
// A key byte is written on acceptance; a key schedule fills the table, then swaps entries in
// read-n, read-j, write-n, write-j steps. A keyed data byte runs read-i, read-j, swap and write-j,
// set by the single read port of the permutation memory, holding requests off until its result
// is registered; unkeyed bytes use a pass state. Synchronous active-low reset clears pointers,
// the keyed flag and the output valid and sets the key length to 1; memories are not cleared.
module rc4_stream_cipher_unit #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [7:0]                 in_key_index,
  input  logic [7:0]                 in_key_byte,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_not_keyed,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rc4_pkg::KLEN_W-1:0] cfg_key_length
);

  import rc4_pkg::*;

  logic [KLEN_W-1:0] key_length_r, key_length_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_not_keyed_r, out_not_keyed_nxt;
  logic              item_ready;
  logic              res_ready;
  rc4_res_t          res;

  rc4_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (in_valid),
    .item_ready     (item_ready),
    .item_opcode    (in_opcode),
    .item_key_index (in_key_index),
    .item_key_byte  (in_key_byte),
    .item_data_byte (in_data_byte),
    .key_length     (key_length_r),
    .res            (res),
    .res_ready      (res_ready)
  );

  assign in_stall  = !item_ready;
  assign cfg_ready = 1'b1;

  // Key length register.
  assign key_length_nxt = (cfg_valid && cfg_ready) ? cfg_key_length : key_length_r;

  // Output register takes a new result when empty or being drained.
  assign res_ready         = !out_valid_r || !out_stall;
  assign out_valid_nxt     = res_ready ? res.valid : out_valid_r;
  assign out_byte_nxt      = (res_ready && res.valid) ? res.out_byte : out_byte_r;
  assign out_not_keyed_nxt = (res_ready && res.valid) ? res.not_keyed : out_not_keyed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KLEN_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      key_length_r <= key_length_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r      <= out_byte_nxt;
    out_not_keyed_r <= out_not_keyed_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_not_keyed = out_not_keyed_r;

endmodule

// File: rtl/rc4_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read; a read of the entry being written returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/rc4_core.sv
// RC4 sequencer: key store, permutation memory, pointers and the step control.
module rc4_core #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic [1:0]               item_opcode,
  input  logic [7:0]               item_key_index,
  input  logic [7:0]               item_key_byte,
  input  logic [7:0]               item_data_byte,
  input  logic [rc4_pkg::KLEN_W-1:0] key_length,
  output rc4_pkg::rc4_res_t        res,
  input  logic                     res_ready
);

  import rc4_pkg::*;

  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  rc4_state_t          state_r, state_nxt;
  logic [PERM_AW-1:0]  i_r, i_nxt;
  logic [PERM_AW-1:0]  j_r, j_nxt;
  logic                keyed_r, keyed_nxt;
  logic [PERM_AW-1:0]  n_r, n_nxt;
  logic [KAW-1:0]      k_r, k_nxt;
  logic [BYTE_W-1:0]   si_r, si_nxt;
  logic [BYTE_W-1:0]   sj_r, sj_nxt;
  logic [PERM_AW-1:0]  t_r, t_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;

  logic                accept;
  rc4_op_t             op;
  logic [KLEN_W-1:0]   eff_len;
  logic [KLEN_W-1:0]   k_inc;
  logic [KAW-1:0]      k_step;
  logic [BYTE_W-1:0]   ks;

  logic                perm_we;
  logic [PERM_AW-1:0]  perm_waddr;
  logic [BYTE_W-1:0]   perm_wdata;
  logic [PERM_AW-1:0]  perm_raddr;
  logic [BYTE_W-1:0]   perm_rdata;

  logic                key_we;
  logic [BYTE_W-1:0]   key_rdata;

  // Permutation table.
  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  // Key store.
  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_KEY_BYTES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (item_key_index[KAW-1:0]),
    .wdata (item_key_byte),
    .raddr (k_r),
    .rdata (key_rdata)
  );

  // Request handshake and opcode decode.
  assign item_ready = (state_r == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign op         = rc4_op_t'(item_opcode);
  assign key_we     = accept && (op == OP_KEY) &&
                      ({1'b0, item_key_index} < KLEN_W'(MAX_KEY_BYTES));

  // A zero or oversized key length uses the whole key store.
  assign eff_len = ((key_length == '0) || (key_length > KLEN_W'(MAX_KEY_BYTES))) ?
                   KLEN_W'(MAX_KEY_BYTES) : key_length;

  // Key index advances cyclically over the effective key length.
  assign k_inc  = KLEN_W'(k_r) + KLEN_W'(1);
  assign k_step = (k_inc == eff_len) ? '0 : KAW'(k_r + KAW'(1));

  // Keystream byte: the read at t was issued before the swap landed, so forward it.
  always_comb begin
    if (t_r == j_r) begin
      ks = si_r;
    end else if (t_r == i_r) begin
      ks = sj_r;
    end else begin
      ks = perm_rdata;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_KSA:   state_nxt = ST_FILL;
            OP_CRYPT: state_nxt = keyed_r ? ST_D_RD_I : ST_PASS;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PASS:   if (res_ready) state_nxt = ST_IDLE;
      ST_FILL:   if (n_r == '1) state_nxt = ST_K_RD_N;
      ST_K_RD_N: state_nxt = ST_K_RD_J;
      ST_K_RD_J: state_nxt = ST_K_WR_N;
      ST_K_WR_N: state_nxt = ST_K_WR_J;
      ST_K_WR_J: state_nxt = (n_r == '1) ? ST_IDLE : ST_K_RD_N;
      ST_D_RD_I: state_nxt = ST_D_RD_J;
      ST_D_RD_J: state_nxt = ST_D_SWAP;
      ST_D_SWAP: state_nxt = ST_D_WR_J;
      ST_D_WR_J: if (res_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory ports and result.
  always_comb begin
    perm_we    = 1'b0;
    perm_waddr = n_r;
    perm_wdata = perm_rdata;
    perm_raddr = i_r;
    res        = '0;
    case (state_r)
      ST_PASS: begin
        res.valid     = 1'b1;
        res.out_byte  = data_r;
        res.not_keyed = 1'b1;
      end
      ST_FILL: begin
        perm_we    = 1'b1;
        perm_waddr = n_r;
        perm_wdata = n_r;
      end
      ST_K_RD_N: begin
        perm_raddr = n_r;
      end
      ST_K_RD_J: begin
        perm_raddr = j_r + perm_rdata + key_rdata;
      end
      ST_K_WR_N: begin
        perm_we    = 1'b1;
        perm_waddr = n_r;
        perm_wdata = perm_rdata;
      end
      ST_K_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = si_r;
      end
      ST_D_RD_I: begin
        perm_raddr = i_r + PERM_AW'(1);
      end
      ST_D_RD_J: begin
        perm_raddr = j_r + perm_rdata;
      end
      ST_D_SWAP: begin
        perm_we    = 1'b1;
        perm_waddr = i_r;
        perm_wdata = perm_rdata;
        perm_raddr = si_r + perm_rdata;
      end
      ST_D_WR_J: begin
        perm_we       = 1'b1;
        perm_waddr    = j_r;
        perm_wdata    = si_r;
        perm_raddr    = t_r;
        res.valid     = 1'b1;
        res.out_byte  = data_r ^ ks;
        res.not_keyed = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Pointer, counter and operand updates.
  always_comb begin
    i_nxt     = i_r;
    j_nxt     = j_r;
    keyed_nxt = keyed_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    t_nxt     = t_r;
    data_nxt  = data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          data_nxt = item_data_byte;
          if (op == OP_KSA) begin
            n_nxt = '0;
            k_nxt = '0;
            j_nxt = '0;
          end
        end
      end
      ST_FILL: begin
        n_nxt = n_r + PERM_AW'(1);
      end
      ST_K_RD_J: begin
        si_nxt = perm_rdata;
        j_nxt  = j_r + perm_rdata + key_rdata;
      end
      ST_K_WR_J: begin
        n_nxt = n_r + PERM_AW'(1);
        k_nxt = k_step;
        if (n_r == '1) begin
          i_nxt     = '0;
          j_nxt     = '0;
          keyed_nxt = 1'b1;
        end
      end
      ST_D_RD_I: begin
        i_nxt = i_r + PERM_AW'(1);
      end
      ST_D_RD_J: begin
        si_nxt = perm_rdata;
        j_nxt  = j_r + perm_rdata;
      end
      ST_D_SWAP: begin
        sj_nxt = perm_rdata;
        t_nxt  = si_r + perm_rdata;
      end
      default: begin
      end
    endcase
  end

  // Control state is reset; operand registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      keyed_r <= 1'b0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      keyed_r <= keyed_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    t_r    <= t_nxt;
    data_r <= data_nxt;
  end

endmodule
